[sv/wsrx_pkg.sv]
package wsrx_pkg;

  localparam int unsigned CfgWidth = 33;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OVERSIZE = 2'd1;
  localparam logic [1:0] STATUS_LEN_HUGE = 2'd2;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       final_flag;
    logic       mask_present;
    logic       byte_valid;
    logic       frame_end;
    logic [1:0] status;
  } result_t;

endpackage

[sv/websocket_rx_deframer.sv]
// websocket frame deframer: takes one stream byte per cycle on push/full while
// full is low and delivers tagged payload bytes and frame markers on empty/pop.
// the header parser decides each byte in the cycle it is accepted, so a byte
// can be taken every cycle that full is low; its result is written into a
// queue of DEPTH entries and shows on the result ports once it is at the head
// of that queue. full rises only while the queue holds DEPTH untaken results.
// header bytes, dropped payload bytes and mask key bytes give no result, except
// for the one marker at the end of an empty frame, a dropped frame or a frame
// whose length field is too large. max_frame_bytes may be written through the
// cfg channel, which is always ready, while no frame is in progress.
module websocket_rx_deframer import wsrx_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          rx_byte,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgWidth-1:0] cfg_data,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          payload_byte,
  output logic [3:0]          frame_opcode,
  output logic                final_flag,
  output logic                mask_present,
  output logic                byte_valid,
  output logic                frame_end,
  output logic [1:0]          status
);

  logic [CfgWidth-1:0] max_frame_bytes;
  logic                accept;
  logic                res_valid;
  result_t             res;
  result_t             head;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= CfgWidth'(1024);
    end else if (cfg_valid && cfg_ready) begin
      max_frame_bytes <= cfg_data;
    end
  end

  wsrx_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (accept),
    .in_byte         (rx_byte),
    .max_frame_bytes (max_frame_bytes),
    .res_valid       (res_valid),
    .res             (res)
  );

  wsrx_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res),
    .rd_en   (pop),
    .rd_data (head),
    .full    (full),
    .empty   (empty)
  );

  assign payload_byte = head.payload_byte;
  assign frame_opcode = head.frame_opcode;
  assign final_flag   = head.final_flag;
  assign mask_present = head.mask_present;
  assign byte_valid   = head.byte_valid;
  assign frame_end    = head.frame_end;
  assign status       = head.status;

`ifndef SYNTH
  // a result produced by the parser must leave the queue holding at least one result
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> !empty)
    else $error("parser result lost");

  // data bytes always carry ok status
  a_data_status: assert property (@(posedge clk) disable iff (rst)
    (!empty && byte_valid) |-> (status == STATUS_OK))
    else $error("data byte with error status");

  // every marker closes its frame
  a_marker_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && !byte_valid) |-> frame_end)
    else $error("marker without frame end");

  // parser only fires on an accepted byte
  a_result_needs_byte: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (push && !full))
    else $error("result without accepted byte");
`endif

endmodule

[sv/wsrx_parser.sv]
module wsrx_parser import wsrx_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  input  logic [CfgWidth-1:0] max_frame_bytes,
  output logic                res_valid,
  output result_t             res
);

  localparam logic [2:0] PH_B0      = 3'd0;
  localparam logic [2:0] PH_B1      = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASKKEY = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic [2:0]  phase, phase_next;
  logic [3:0]  opcode, opcode_next;
  logic        fin, fin_next;
  logic [31:0] len_acc, len_acc_next;
  logic        len_huge, len_huge_next;
  logic [3:0]  field_cnt, field_cnt_next;
  logic [31:0] remaining, remaining_next;
  logic        masked, masked_next;
  logic [3:0]  hdr_size, hdr_size_next;
  logic        dropping, dropping_next;

  logic        len_done;
  logic        hdr_done;
  logic        last;
  logic [6:0]  len7;
  logic [32:0] total;
  logic        oversize;

  always_comb begin
    phase_next     = phase;
    opcode_next    = opcode;
    fin_next       = fin;
    len_acc_next   = len_acc;
    len_huge_next  = len_huge;
    field_cnt_next = field_cnt;
    remaining_next = remaining;
    masked_next    = masked;
    hdr_size_next  = hdr_size;
    dropping_next  = dropping;
    len_done       = 1'b0;
    hdr_done       = 1'b0;
    last           = 1'b0;
    len7           = in_byte[6:0];
    res_valid      = 1'b0;
    res.payload_byte = 8'd0;
    res.byte_valid   = 1'b0;
    res.frame_end    = 1'b1;
    res.status       = STATUS_OK;

    case (phase)
      PH_B1: begin
        masked_next   = in_byte[7];
        hdr_size_next = 4'd2;
        len_acc_next  = 32'd0;
        len_huge_next = 1'b0;
        if (len7 == 7'd126) begin
          hdr_size_next  = 4'd4;
          field_cnt_next = 4'd2;
          phase_next     = PH_EXTLEN;
        end else if (len7 == 7'd127) begin
          hdr_size_next  = 4'd10;
          field_cnt_next = 4'd8;
          phase_next     = PH_EXTLEN;
        end else begin
          len_acc_next = {25'd0, len7};
          len_done     = 1'b1;
        end
      end
      PH_EXTLEN: begin
        // bytes shifted out of the top word mark a length beyond 32 bits
        len_acc_next   = {len_acc[23:0], in_byte};
        len_huge_next  = len_huge | (len_acc[31:24] != 8'd0);
        field_cnt_next = (field_cnt == 4'd0) ? 4'd0 : field_cnt - 4'd1;
        if (field_cnt_next == 4'd0) begin
          if (len_huge_next) begin
            phase_next = PH_B0;
            res_valid  = 1'b1;
            res.status = STATUS_LEN_HUGE;
          end else begin
            len_done = 1'b1;
          end
        end
      end
      PH_MASKKEY: begin
        field_cnt_next = (field_cnt == 4'd0) ? 4'd0 : field_cnt - 4'd1;
        if (field_cnt_next == 4'd0) begin
          hdr_done = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        remaining_next = (remaining == 32'd0) ? 32'd0 : remaining - 32'd1;
        last           = (remaining_next == 32'd0);
        if (last) begin
          phase_next = PH_B0;
        end
        if (dropping) begin
          if (last) begin
            dropping_next = 1'b0;
            res_valid     = 1'b1;
            res.status    = STATUS_OVERSIZE;
          end
        end else begin
          res_valid        = 1'b1;
          res.payload_byte = in_byte;
          res.byte_valid   = 1'b1;
          res.frame_end    = last;
        end
      end
      default: begin
        opcode_next   = in_byte[3:0];
        fin_next      = in_byte[7];
        masked_next   = 1'b0;
        dropping_next = 1'b0;
        phase_next    = PH_B1;
      end
    endcase

    if (len_done) begin
      if (masked_next) begin
        hdr_size_next  = hdr_size_next + 4'd4;
        field_cnt_next = 4'd4;
        phase_next     = PH_MASKKEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    total    = {1'b0, len_acc_next} + {29'd0, hdr_size_next};
    oversize = (total > max_frame_bytes);

    if (hdr_done) begin
      remaining_next = len_acc_next;
      if (len_acc_next == 32'd0) begin
        // empty frame gives a single marker
        phase_next = PH_B0;
        res_valid  = 1'b1;
        res.status = oversize ? STATUS_OVERSIZE : STATUS_OK;
      end else begin
        dropping_next = oversize;
        phase_next    = PH_PAYLOAD;
      end
    end

    // a result only comes with an accepted byte
    if (!in_valid) begin
      res_valid = 1'b0;
    end

    res.frame_opcode = opcode_next;
    res.final_flag   = fin_next;
    res.mask_present = masked_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_B0;
      masked   <= 1'b0;
      dropping <= 1'b0;
    end else if (in_valid) begin
      phase    <= phase_next;
      masked   <= masked_next;
      dropping <= dropping_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      opcode    <= opcode_next;
      fin       <= fin_next;
      len_acc   <= len_acc_next;
      len_huge  <= len_huge_next;
      field_cnt <= field_cnt_next;
      remaining <= remaining_next;
      hdr_size  <= hdr_size_next;
    end
  end

endmodule

[sv/wsrx_fifo.sv]
module wsrx_fifo import wsrx_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  result_t wr_data,
  input  logic    rd_en,
  output result_t rd_data,
  output logic    full,
  output logic    empty
);

  localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntWidth = $clog2(DEPTH + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

  result_t             slots [DEPTH];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CntWidth-1:0] count;
  logic                do_wr;
  logic                do_rd;

  assign full    = (count == FullCnt);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[tb/tb_websocket_rx_deframer.sv]
`timescale 1ns / 100ps

module tb_websocket_rx_deframer;
  import wsrx_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_EXTENDED,
    PH_KEY,
    PH_DATA
  } parse_phase_t;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [CfgWidth-1:0] LIMIT_RESET = 33'd1024;
  localparam logic [CfgWidth-1:0] LIMIT_LOW = 33'd2;
  localparam logic [CfgWidth-1:0] LIMIT_HIGH = 33'd4294967309;

  typedef struct packed {
    logic                is_cfg;
    logic [CfgWidth-1:0] cfg_value;
    logic [7:0]          data;
    logic                typed;
    result_t             want;
  } script_row_t;

  localparam int ScriptLen = 28;
  localparam script_row_t SCRIPT [ScriptLen] = '{
    // masked one-byte frame, rsv bits set, opcode 9
    '{1'b0, 33'd0, 8'hF9, 1'b0, '0},
    '{1'b0, 33'd0, 8'h81, 1'b0, '0},
    '{1'b0, 33'd0, 8'h37, 1'b0, '0},
    '{1'b0, 33'd0, 8'hC8, 1'b0, '0},
    '{1'b0, 33'd0, 8'h00, 1'b0, '0},
    '{1'b0, 33'd0, 8'hFF, 1'b0, '0},
    '{1'b0, 33'd0, 8'hFF, 1'b1, '{8'hFF, 4'h9, 1'b1, 1'b1, 1'b1, 1'b1, STATUS_OK}},
    // 16-bit length form
    '{1'b0, 33'd0, 8'h02, 1'b0, '0},
    '{1'b0, 33'd0, 8'h7E, 1'b0, '0},
    '{1'b0, 33'd0, 8'h00, 1'b0, '0},
    '{1'b0, 33'd0, 8'h01, 1'b0, '0},
    '{1'b0, 33'd0, 8'hA5, 1'b1, '{8'hA5, 4'h2, 1'b0, 1'b0, 1'b1, 1'b1, STATUS_OK}},
    // 64-bit length above 32 bits, parser resyncs
    '{1'b0, 33'd0, 8'h0F, 1'b0, '0},
    '{1'b0, 33'd0, 8'hFF, 1'b0, '0},
    '{1'b0, 33'd0, 8'h00, 1'b0, '0},
    '{1'b0, 33'd0, 8'h00, 1'b0, '0},
    '{1'b0, 33'd0, 8'h00, 1'b0, '0},
    '{1'b0, 33'd0, 8'h01, 1'b0, '0},
    '{1'b0, 33'd0, 8'h00, 1'b0, '0},
    '{1'b0, 33'd0, 8'h00, 1'b0, '0},
    '{1'b0, 33'd0, 8'h00, 1'b0, '0},
    '{1'b0, 33'd0, 8'h00, 1'b1, '{8'h00, 4'hF, 1'b0, 1'b1, 1'b0, 1'b1, STATUS_LEN_HUGE}},
    '{1'b1, LIMIT_LOW, 8'h00, 1'b0, '0},
    // empty frame exactly at the limit
    '{1'b0, 33'd0, 8'h88, 1'b0, '0},
    '{1'b0, 33'd0, 8'h00, 1'b1, '{8'h00, 4'h8, 1'b1, 1'b0, 1'b0, 1'b1, STATUS_OK}},
    // one byte over the limit
    '{1'b0, 33'd0, 8'h82, 1'b0, '0},
    '{1'b0, 33'd0, 8'h01, 1'b0, '0},
    '{1'b0, 33'd0, 8'h33, 1'b1, '{8'h00, 4'h2, 1'b1, 1'b0, 1'b0, 1'b1, STATUS_OVERSIZE}}
  };

  logic                clk;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [7:0]          rx_byte = 8'h00;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgWidth-1:0] cfg_data = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [7:0]          payload_byte;
  logic [3:0]          frame_opcode;
  logic                final_flag;
  logic                mask_present;
  logic                byte_valid;
  logic                frame_end;
  logic [1:0]          status;

  websocket_rx_deframer dut (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // deframer state as seen by the checker
  parse_phase_t        phase_q = PH_HEADER;
  logic [7:0]          lead_byte = '0;
  logic [63:0]         length_acc = '0;
  logic [3:0]          field_left = '0;
  logic [31:0]         bytes_left = '0;
  logic                masked_q = 1'b0;
  logic [3:0]          header_len = '0;
  logic                dropping_q = 1'b0;
  logic [CfgWidth-1:0] frame_limit = LIMIT_RESET;

  result_t     due_results[$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_fed = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  function automatic result_t tag_result(logic [7:0] data, logic valid, logic end_mark,
                                         logic [1:0] st);
    result_t r;
    r.payload_byte = data;
    r.frame_opcode = lead_byte[3:0];
    r.final_flag   = lead_byte[7];
    r.mask_present = masked_q;
    r.byte_valid   = valid;
    r.frame_end    = end_mark;
    r.status       = st;
    return r;
  endfunction

  function automatic bit close_header(output result_t r);
    logic [63:0] total;
    logic        too_big;
    total = 64'(header_len) + 64'(length_acc[31:0]);
    too_big = total > 64'(frame_limit);
    bytes_left = length_acc[31:0];
    r = '0;
    if (bytes_left == 0) begin
      phase_q = PH_HEADER;
      r = tag_result(8'h00, 1'b0, 1'b1, too_big ? STATUS_OVERSIZE : STATUS_OK);
      return 1'b1;
    end
    dropping_q = too_big;
    phase_q = PH_DATA;
    return 1'b0;
  endfunction

  function automatic bit close_length(output result_t r);
    r = '0;
    if (masked_q) begin
      header_len = header_len + 4'd4;
      field_left = 4'd4;
      phase_q = PH_KEY;
      return 1'b0;
    end
    return close_header(r);
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    bit produced;
    bit is_last;
    produced = 1'b0;
    r = '0;
    case (phase_q)
      PH_LENGTH: begin
        masked_q = b[7];
        header_len = 4'd2;
        length_acc = '0;
        if (b[6:0] == LEN_EXT16) begin
          header_len = 4'd4;
          field_left = 4'd2;
          phase_q = PH_EXTENDED;
        end else if (b[6:0] == LEN_EXT64) begin
          header_len = 4'd10;
          field_left = 4'd8;
          phase_q = PH_EXTENDED;
        end else begin
          length_acc = 64'(b[6:0]);
          produced = close_length(r);
        end
      end
      PH_EXTENDED: begin
        length_acc = {length_acc[55:0], b};
        if (field_left != 0) field_left = field_left - 4'd1;
        if (field_left == 0) begin
          if (length_acc[63:32] != 0) begin
            phase_q = PH_HEADER;
            r = tag_result(8'h00, 1'b0, 1'b1, STATUS_LEN_HUGE);
            produced = 1'b1;
          end else begin
            produced = close_length(r);
          end
        end
      end
      PH_KEY: begin
        if (field_left != 0) field_left = field_left - 4'd1;
        if (field_left == 0) produced = close_header(r);
      end
      PH_DATA: begin
        if (bytes_left != 0) bytes_left = bytes_left - 32'd1;
        is_last = (bytes_left == 0);
        if (is_last) phase_q = PH_HEADER;
        if (!dropping_q) begin
          r = tag_result(b, 1'b1, is_last, STATUS_OK);
          produced = 1'b1;
        end else if (is_last) begin
          dropping_q = 1'b0;
          r = tag_result(8'h00, 1'b0, 1'b1, STATUS_OVERSIZE);
          produced = 1'b1;
        end
      end
      default: begin
        lead_byte = b;
        masked_q = 1'b0;
        dropping_q = 1'b0;
        phase_q = PH_LENGTH;
      end
    endcase
    return produced;
  endfunction

  function automatic void note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
  endfunction

  function automatic string show(result_t r);
    return $sformatf("byte %h op %h fin %b mask %b valid %b end %b st %0d", r.payload_byte,
                     r.frame_opcode, r.final_flag, r.mask_present, r.byte_valid, r.frame_end,
                     r.status);
  endfunction

  task automatic feed_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input result_t want = '0);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    bytes_fed++;
    if (deframe_byte(b, r) && !typed) due_results.push_back(r);
    if (typed) due_results.push_back(want);
  endtask

  // bring the stream back to a frame boundary with short lengths
  task automatic flush_to_boundary();
    while (phase_q != PH_HEADER)
      feed_byte(phase_q == PH_EXTENDED ? 8'h00 : 8'($urandom));
  endtask

  task automatic write_limit(input logic [CfgWidth-1:0] value);
    push <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    frame_limit = value;
  endtask

  task automatic send_frame();
    logic [7:0]  head;
    logic        masked_frame;
    logic [63:0] len;
    logic [31:0] hi;
    int unsigned pick;
    int unsigned form;
    bit          huge;
    head = 8'($urandom);
    masked_frame = 1'($urandom_range(1));
    pick = $urandom_range(99);
    huge = 1'b0;
    form = $urandom_range(9);
    if (pick < 8) begin
      hi = $urandom;
      if (hi == 0) hi = 32'd1;
      len = {hi, 32'($urandom)};
      huge = 1'b1;
      form = 9;
    end else if (pick < 55) begin
      len = 64'($urandom_range(6));
    end else if (pick < 85) begin
      len = 64'($urandom_range(40, 7));
    end else if (pick < 98) begin
      len = 64'($urandom_range(150, 41));
    end else begin
      len = 64'($urandom_range(400, 151));
    end
    // long frames need an extended form, 16-bit mostly
    if (len >= 126 && form < 7) form = 7;
    if (len >= 126 && !huge && form == 8) form = $urandom_range(1) ? 7 : 9;
    feed_byte(head);
    if (form < 7) begin
      feed_byte({masked_frame, len[6:0]});
    end else if (form < 9) begin
      feed_byte({masked_frame, LEN_EXT16});
      feed_byte(len[15:8]);
      feed_byte(len[7:0]);
    end else begin
      feed_byte({masked_frame, LEN_EXT64});
      for (int i = 7; i >= 0; i--) feed_byte(len[8*i +: 8]);
    end
    if (!huge) begin
      if (masked_frame) repeat (4) feed_byte(8'($urandom));
      repeat (int'(len[31:0])) feed_byte(8'($urandom));
    end
  endtask

  // result side: pop at random, check every transaction against the oldest prediction
  initial begin
    result_t got;
    result_t want;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got = {payload_byte, frame_opcode, final_flag, mask_present, byte_valid, frame_end,
               status};
        if (due_results.size() == 0) begin
          note_failure({"unexpected result: ", show(got)});
        end else begin
          want = due_results.pop_front();
          if (got.payload_byte !== want.payload_byte || got.frame_opcode !== want.frame_opcode ||
              got.final_flag !== want.final_flag || got.mask_present !== want.mask_present ||
              got.byte_valid !== want.byte_valid || got.frame_end !== want.frame_end ||
              got.status !== want.status)
            note_failure({"mismatch: expected ", show(want), " got ", show(got)});
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    logic [CfgWidth-1:0] limit;
    int unsigned         stop_at;
    send_idle_pct = 29;
    recv_idle_pct = 47;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < ScriptLen; i++) begin
      if (SCRIPT[i].is_cfg) write_limit(SCRIPT[i].cfg_value);
      else feed_byte(SCRIPT[i].data, SCRIPT[i].typed, SCRIPT[i].want);
    end

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          limit = LIMIT_HIGH;
          stop_at = bytes_fed + 450;
        end
        1: begin
          limit = LIMIT_LOW;
          stop_at = bytes_fed + 250;
        end
        2: begin
          limit = 33'($urandom_range(200, 16));
          stop_at = bytes_fed + 450;
        end
        3: begin
          limit = 33'($urandom_range(40, 2));
          stop_at = bytes_fed + 300;
        end
        default: begin
          limit = 33'($urandom_range(600, 60));
          stop_at = bytes_fed + 450;
        end
      endcase
      if (p == 2) begin
        send_idle_pct = 47;
        recv_idle_pct = 29;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_limit(limit);
      while (bytes_fed < stop_at) begin
        if ($urandom_range(9) == 0) begin
          // broken header: one or two stray bytes, then resync
          repeat ($urandom_range(2, 1)) feed_byte(8'($urandom));
          flush_to_boundary();
        end else begin
          send_frame();
        end
      end
      flush_to_boundary();
    end

    push <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
sv/wsrx_pkg.sv
sv/wsrx_parser.sv
sv/wsrx_fifo.sv
sv/websocket_rx_deframer.sv
tb/tb_websocket_rx_deframer.sv
